FILE: hw/rtl/qrg_pkg.sv
// Shared constants, command codes and types for the Givens QR block.
`default_nettype none
package qrg_pkg;

    localparam int ROWS_DEF  = 4;
    localparam int COLS_DEF  = 4;
    localparam int DATA_W    = 32;
    localparam int CS_W      = 18;
    localparam int ITER_STEPS = 17;

    localparam logic signed [CS_W-1:0] CS_ONE = 18'sd65536;
    localparam logic [DATA_W-1:0]      FX_ONE = 32'h0001_0000;

    // datapath operations
    localparam logic [3:0] OP_NONE      = 4'd0;
    localparam logic [3:0] OP_LDA       = 4'd1;
    localparam logic [3:0] OP_LDB       = 4'd2;
    localparam logic [3:0] OP_LDX       = 4'd3;
    localparam logic [3:0] OP_LDY       = 4'd4;
    localparam logic [3:0] OP_SPECIAL   = 4'd5;
    localparam logic [3:0] OP_DIV_RATIO = 4'd6;
    localparam logic [3:0] OP_DIV_U     = 4'd7;
    localparam logic [3:0] OP_DIV_STEP  = 4'd8;
    localparam logic [3:0] OP_SAVE_RA   = 4'd9;
    localparam logic [3:0] OP_SQ_INIT   = 4'd10;
    localparam logic [3:0] OP_SQ_STEP   = 4'd11;
    localparam logic [3:0] OP_SAVE_U    = 4'd12;
    localparam logic [3:0] OP_SET_CS    = 4'd13;

    // multiplier operand select
    localparam logic [2:0] MS_HOLD = 3'd0;
    localparam logic [2:0] MS_RR   = 3'd1;
    localparam logic [2:0] MS_UR   = 3'd2;
    localparam logic [2:0] MS_CX   = 3'd3;
    localparam logic [2:0] MS_SY   = 3'd4;
    localparam logic [2:0] MS_SX   = 3'd5;
    localparam logic [2:0] MS_CY   = 3'd6;

    // accumulator operations
    localparam logic [1:0] AC_HOLD = 2'd0;
    localparam logic [1:0] AC_LOAD = 2'd1;
    localparam logic [1:0] AC_SUB  = 2'd2;
    localparam logic [1:0] AC_ADD  = 2'd3;

    // store write source
    localparam logic [1:0] WS_ELEM = 2'd0;
    localparam logic [1:0] WS_RES  = 2'd1;
    localparam logic [1:0] WS_ONE  = 2'd2;
    localparam logic [1:0] WS_ZERO = 2'd3;

    typedef struct packed {
        logic [3:0] op;
        logic [2:0] mul_sel;
        logic [1:0] acc_op;
        logic       res_en;
        logic       rd_q;
        logic       wr_r;
        logic       wr_q;
        logic [1:0] wr_src;
    } t_dp_cmd;

    typedef struct packed {
        logic special;
    } t_dp_status;

endpackage
`default_nettype wire

FILE: hw/rtl/qr_decomposition_givens.sv
// Top level of the Givens-rotation QR decomposition block.
`default_nettype none
// Load a ROWS x COLS matrix (COLS <= ROWS) one signed Q16.16 word per cycle,
// row-major, with start while busy is low. The word that completes the matrix
// raises busy. The block sets Q to the identity, then runs one Givens rotation
// per entry below the diagonal. A rotation with neither operand zero first runs
// two 17-step divides and a 17-step square root; every rotation then updates its
// COLS + ROWS element pairs in turn through the single multiplier. It then emits
// Q and R row-major, one word per cycle on o_valid (ROWS*ROWS + ROWS*COLS words);
// the receiver cannot stall.
module qr_decomposition_givens #(
    parameter int ROWS = qrg_pkg::ROWS_DEF,
    parameter int COLS = qrg_pkg::COLS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    input  wire logic signed [qrg_pkg::DATA_W-1:0] i_element,
    output logic                                   busy,
    output logic                                   o_valid,
    output logic                                   o_which_matrix,
    output logic [1:0]                             o_row,
    output logic [1:0]                             o_col,
    output logic signed [qrg_pkg::DATA_W-1:0]      o_value,
    output logic                                   o_last_of_run
);
    import qrg_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;
    logic [$clog2(ROWS*COLS)-1:0] raddr_r;
    logic [$clog2(ROWS*ROWS)-1:0] raddr_q, waddr;

    qrg_ctrl #(.ROWS(ROWS), .COLS(COLS)) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_status      (status),
        .o_busy        (busy),
        .o_cmd         (cmd),
        .o_raddr_r     (raddr_r),
        .o_raddr_q     (raddr_q),
        .o_waddr       (waddr),
        .o_valid       (o_valid),
        .o_which_matrix(o_which_matrix),
        .o_row         (o_row),
        .o_col         (o_col),
        .o_last_of_run (o_last_of_run)
    );

    qrg_datapath #(.ROWS(ROWS), .COLS(COLS)) u_dp (
        .i_clk    (i_clk),
        .i_cmd    (cmd),
        .i_raddr_r(raddr_r),
        .i_raddr_q(raddr_q),
        .i_waddr  (waddr),
        .i_element(i_element),
        .o_status (status),
        .o_value  (o_value)
    );
endmodule
`default_nettype wire

FILE: hw/rtl/qrg_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module qrg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: hw/rtl/qrg_datapath.sv
// Datapath: R and Q stores, divider, square root, multiplier and accumulator.
`default_nettype none
module qrg_datapath #(
    parameter int ROWS = qrg_pkg::ROWS_DEF,
    parameter int COLS = qrg_pkg::COLS_DEF
) (
    input  wire logic                                  i_clk,
    input  wire qrg_pkg::t_dp_cmd                      i_cmd,
    input  wire logic [$clog2(ROWS*COLS)-1:0]          i_raddr_r,
    input  wire logic [$clog2(ROWS*ROWS)-1:0]          i_raddr_q,
    input  wire logic [$clog2(ROWS*ROWS)-1:0]          i_waddr,
    input  wire logic signed [qrg_pkg::DATA_W-1:0]     i_element,
    output qrg_pkg::t_dp_status                        o_status,
    output logic signed [qrg_pkg::DATA_W-1:0]          o_value
);
    import qrg_pkg::*;

    localparam int RAW = $clog2(ROWS*COLS);

    logic [DATA_W-1:0] rdata_r, rdata_q, wdata;
    logic signed [DATA_W-1:0] rd;
    logic r_rsel;

    logic signed [DATA_W-1:0] r_a, r_b, r_x, r_y, r_res;
    logic a_neg, b_neg, a_zero, b_zero, b_gt;
    logic [31:0] ma, mb, small_mag, large_mag;

    logic [31:0] r_rem, r_den;
    logic [16:0] r_dlo, r_quo, r_ra, r_u;
    logic [33:0] div_diff;
    logic        div_take;

    logic [33:0] r_sv;
    logic [18:0] r_srem;
    logic [16:0] r_root;
    logic [20:0] sq_rem2, sq_trial;
    logic [21:0] sq_diff;
    logic        sq_take;
    logic [17:0] t_val;

    logic signed [CS_W-1:0] r_c, r_s, u_pos, m_pos;
    logic signed [32:0] mul_a;
    logic signed [18:0] mul_b;
    logic signed [51:0] prod_w, r_prod, r_acc, biased;
    logic signed [35:0] sh;
    logic [DATA_W-1:0] res_v;
    logic fits;

    qrg_ram #(.WIDTH(DATA_W), .DEPTH(ROWS*COLS)) u_rram (
        .i_clk  (i_clk),
        .i_we   (i_cmd.wr_r),
        .i_waddr(i_waddr[RAW-1:0]),
        .i_wdata(wdata),
        .i_raddr(i_raddr_r),
        .o_rdata(rdata_r)
    );

    qrg_ram #(.WIDTH(DATA_W), .DEPTH(ROWS*ROWS)) u_qram (
        .i_clk  (i_clk),
        .i_we   (i_cmd.wr_q),
        .i_waddr(i_waddr),
        .i_wdata(wdata),
        .i_raddr(i_raddr_q),
        .o_rdata(rdata_q)
    );

    always_comb begin
        unique case (i_cmd.wr_src)
            WS_ELEM: wdata = i_element;
            WS_RES:  wdata = r_res;
            WS_ONE:  wdata = FX_ONE;
            default: wdata = '0;
        endcase
    end

    assign rd      = r_rsel ? rdata_q : rdata_r;
    assign o_value = rd;

    // operand analysis
    assign a_neg     = r_a[31];
    assign b_neg     = r_b[31];
    assign a_zero    = (r_a == '0);
    assign b_zero    = (r_b == '0);
    assign ma        = a_neg ? (~r_a + 32'd1) : r_a;
    assign mb        = b_neg ? (~r_b + 32'd1) : r_b;
    assign b_gt      = (mb > ma);
    assign small_mag = b_gt ? ma : mb;
    assign large_mag = b_gt ? mb : ma;
    assign o_status.special = a_zero | b_zero;

    // restoring divider, one quotient bit per step
    assign div_diff = {1'b0, r_rem, r_dlo[16]} - {2'b00, r_den};
    assign div_take = ~div_diff[33];

    // digit-by-digit square root, two radicand bits per step
    assign sq_rem2  = {r_srem, r_sv[33:32]};
    assign sq_trial = {2'b00, r_root, 2'b01};
    assign sq_diff  = {1'b0, sq_rem2} - {1'b0, sq_trial};
    assign sq_take  = ~sq_diff[21];
    assign t_val    = 18'd65536 + {1'b0, r_prod[32:16]};

    assign u_pos = {1'b0, r_u};
    assign m_pos = {1'b0, r_prod[32:16]};

    always_comb begin
        unique case (i_cmd.mul_sel)
            MS_RR:   begin mul_a = {16'b0, r_ra}; mul_b = {2'b00, r_ra}; end
            MS_UR:   begin mul_a = {16'b0, r_u};  mul_b = {2'b00, r_ra}; end
            MS_CX:   begin mul_a = 33'(r_x); mul_b = 19'(r_c); end
            MS_SY:   begin mul_a = 33'(r_y); mul_b = 19'(r_s); end
            MS_SX:   begin mul_a = 33'(r_x); mul_b = 19'(r_s); end
            MS_CY:   begin mul_a = 33'(r_y); mul_b = 19'(r_c); end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end
    assign prod_w = mul_a * mul_b;

    // divide by 2^16 toward zero, then saturate
    assign biased = r_acc + (r_acc[51] ? 52'sd65535 : 52'sd0);
    assign sh     = biased[51:16];
    assign fits   = (&sh[35:31]) | ~(|sh[35:31]);
    assign res_v  = fits ? sh[31:0] : (sh[35] ? 32'h8000_0000 : 32'h7fff_ffff);

    always_ff @(posedge i_clk) begin
        r_rsel <= i_cmd.rd_q;
        if (i_cmd.mul_sel != MS_HOLD) begin
            r_prod <= prod_w;
        end
        unique case (i_cmd.acc_op)
            AC_LOAD: r_acc <= r_prod;
            AC_SUB:  r_acc <= r_acc - r_prod;
            AC_ADD:  r_acc <= r_acc + r_prod;
            default: r_acc <= r_acc;
        endcase
        if (i_cmd.res_en) begin
            r_res <= res_v;
        end
        unique case (i_cmd.op)
            OP_LDA: r_a <= rd;
            OP_LDB: r_b <= rd;
            OP_LDX: r_x <= rd;
            OP_LDY: r_y <= rd;
            OP_SPECIAL: begin
                if (b_zero) begin
                    r_c <= a_neg ? -CS_ONE : CS_ONE;
                    r_s <= '0;
                end else begin
                    r_c <= '0;
                    r_s <= b_neg ? CS_ONE : -CS_ONE;
                end
            end
            OP_DIV_RATIO: begin
                r_rem <= {1'b0, small_mag[31:1]};
                r_dlo <= {small_mag[0], 16'b0};
                r_den <= large_mag;
                r_quo <= '0;
            end
            OP_DIV_U: begin
                r_rem <= 32'h0000_8000;
                r_dlo <= '0;
                r_den <= {15'b0, r_root};
                r_quo <= '0;
            end
            OP_DIV_STEP: begin
                r_rem <= div_take ? div_diff[31:0] : {r_rem[30:0], r_dlo[16]};
                r_dlo <= {r_dlo[15:0], 1'b0};
                r_quo <= {r_quo[15:0], div_take};
            end
            OP_SAVE_RA: r_ra <= r_quo;
            OP_SQ_INIT: begin
                r_sv   <= {t_val, 16'b0};
                r_srem <= '0;
                r_root <= '0;
            end
            OP_SQ_STEP: begin
                r_srem <= sq_take ? sq_diff[18:0] : sq_rem2[18:0];
                r_root <= {r_root[15:0], sq_take};
                r_sv   <= {r_sv[31:0], 2'b00};
            end
            OP_SAVE_U: r_u <= r_quo;
            OP_SET_CS: begin
                if (b_gt) begin
                    r_c <= a_neg ? -m_pos : m_pos;
                    r_s <= b_neg ? u_pos : -u_pos;
                end else begin
                    r_c <= a_neg ? -u_pos : u_pos;
                    r_s <= b_neg ? m_pos : -m_pos;
                end
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

FILE: hw/rtl/qrg_ctrl.sv
// Controller: load counting, rotation sequencing and result emission.
`default_nettype none
module qrg_ctrl #(
    parameter int ROWS = qrg_pkg::ROWS_DEF,
    parameter int COLS = qrg_pkg::COLS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire qrg_pkg::t_dp_status           i_status,
    output logic                               o_busy,
    output qrg_pkg::t_dp_cmd                   o_cmd,
    output logic [$clog2(ROWS*COLS)-1:0]       o_raddr_r,
    output logic [$clog2(ROWS*ROWS)-1:0]       o_raddr_q,
    output logic [$clog2(ROWS*ROWS)-1:0]       o_waddr,
    output logic                               o_valid,
    output logic                               o_which_matrix,
    output logic [1:0]                         o_row,
    output logic [1:0]                         o_col,
    output logic                               o_last_of_run
);
    import qrg_pkg::*;

    localparam int RAW    = $clog2(ROWS*COLS);
    localparam int QAW    = $clog2(ROWS*ROWS);
    localparam int RW     = $clog2(ROWS);
    localparam int R_SIZE = ROWS * COLS;

    localparam logic [4:0] ST_LOAD  = 5'd0;
    localparam logic [4:0] ST_QINIT = 5'd1;
    localparam logic [4:0] ST_RA    = 5'd2;
    localparam logic [4:0] ST_RB    = 5'd3;
    localparam logic [4:0] ST_LB    = 5'd4;
    localparam logic [4:0] ST_CHK   = 5'd5;
    localparam logic [4:0] ST_DIV1  = 5'd6;
    localparam logic [4:0] ST_SRA   = 5'd7;
    localparam logic [4:0] ST_MRR   = 5'd8;
    localparam logic [4:0] ST_SQI   = 5'd9;
    localparam logic [4:0] ST_SQ    = 5'd10;
    localparam logic [4:0] ST_D2I   = 5'd11;
    localparam logic [4:0] ST_DIV2  = 5'd12;
    localparam logic [4:0] ST_SU    = 5'd13;
    localparam logic [4:0] ST_MUR   = 5'd14;
    localparam logic [4:0] ST_CS    = 5'd15;
    localparam logic [4:0] ST_PAIR  = 5'd16;
    localparam logic [4:0] ST_EMIT  = 5'd17;

    // element rotation steps
    localparam logic [3:0] PS_RDX = 4'd0;
    localparam logic [3:0] PS_RDY = 4'd1;
    localparam logic [3:0] PS_LDY = 4'd2;
    localparam logic [3:0] PS_MCX = 4'd3;
    localparam logic [3:0] PS_MSY = 4'd4;
    localparam logic [3:0] PS_MSX = 4'd5;
    localparam logic [3:0] PS_MCY = 4'd6;
    localparam logic [3:0] PS_WRX = 4'd7;
    localparam logic [3:0] PS_RSY = 4'd8;
    localparam logic [3:0] PS_WRY = 4'd9;

    logic [4:0]    r_state, n_state;
    logic [RAW-1:0] r_lc, n_lc;
    logic [4:0]    r_cnt, n_cnt;
    logic [3:0]    r_step, n_step;
    logic [RW-1:0] r_i, n_i, r_j, n_j, r_k, n_k, r_row, n_row, r_col, n_col;
    logic          r_onq, n_onq, r_mat, n_mat;
    logic          r_valid, n_valid;
    logic          r_emat, n_emat, r_elast, n_elast;
    logic [1:0]    r_erow, n_erow, r_ecol, n_ecol;

    logic [RW-1:0]  im1;
    logic [RAW-1:0] xr, yr;
    logic [QAW-1:0] xq, yq;
    logic           iter_end, col_end;

    function automatic logic [RAW-1:0] raddr(input logic [RW-1:0] row, input logic [RW-1:0] col);
        raddr = RAW'(row) * RAW'(COLS) + RAW'(col);
    endfunction

    function automatic logic [QAW-1:0] qaddr(input logic [RW-1:0] row, input logic [RW-1:0] col);
        qaddr = QAW'(row) * QAW'(ROWS) + QAW'(col);
    endfunction

    assign im1      = r_i - RW'(1);
    assign xr       = raddr(im1, r_k);
    assign yr       = raddr(r_i, r_k);
    assign xq       = qaddr(r_k, im1);
    assign yq       = qaddr(r_k, r_i);
    assign iter_end = (r_cnt == 5'(ITER_STEPS - 1));
    assign col_end  = r_mat ? (r_col == RW'(COLS - 1)) : (r_col == RW'(ROWS - 1));

    assign o_busy         = (r_state != ST_LOAD);
    assign o_valid        = r_valid;
    assign o_which_matrix = r_emat;
    assign o_row          = r_erow;
    assign o_col          = r_ecol;
    assign o_last_of_run  = r_elast;

    always_comb begin
        n_state = r_state;
        n_lc    = r_lc;
        n_cnt   = r_cnt;
        n_step  = r_step;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        n_row   = r_row;
        n_col   = r_col;
        n_onq   = r_onq;
        n_mat   = r_mat;
        n_valid = 1'b0;
        n_emat  = r_emat;
        n_erow  = r_erow;
        n_ecol  = r_ecol;
        n_elast = 1'b0;
        o_cmd   = '{op: OP_NONE, mul_sel: MS_HOLD, acc_op: AC_HOLD, res_en: 1'b0,
                    rd_q: 1'b0, wr_r: 1'b0, wr_q: 1'b0, wr_src: WS_ELEM};
        o_raddr_r = '0;
        o_raddr_q = '0;
        o_waddr   = '0;

        unique case (r_state)
            ST_LOAD: begin
                if (i_start) begin
                    o_cmd.wr_r = 1'b1;
                    o_waddr    = QAW'(r_lc);
                    if (r_lc == RAW'(R_SIZE - 1)) begin
                        n_lc    = '0;
                        n_row   = '0;
                        n_col   = '0;
                        n_state = ST_QINIT;
                    end else begin
                        n_lc = r_lc + RAW'(1);
                    end
                end
            end
            ST_QINIT: begin
                o_cmd.wr_q   = 1'b1;
                o_cmd.wr_src = (r_row == r_col) ? WS_ONE : WS_ZERO;
                o_waddr      = qaddr(r_row, r_col);
                if (r_col == RW'(ROWS - 1)) begin
                    n_col = '0;
                    if (r_row == RW'(ROWS - 1)) begin
                        n_i     = RW'(ROWS - 1);
                        n_j     = '0;
                        n_state = ST_RA;
                    end else begin
                        n_row = r_row + RW'(1);
                    end
                end else begin
                    n_col = r_col + RW'(1);
                end
            end
            ST_RA: begin
                o_raddr_r = raddr(im1, r_j);
                n_state   = ST_RB;
            end
            ST_RB: begin
                o_raddr_r = raddr(r_i, r_j);
                o_cmd.op  = OP_LDA;
                n_state   = ST_LB;
            end
            ST_LB: begin
                o_cmd.op = OP_LDB;
                n_state  = ST_CHK;
            end
            ST_CHK: begin
                n_cnt  = '0;
                n_k    = '0;
                n_onq  = 1'b0;
                n_step = PS_RDX;
                if (i_status.special) begin
                    o_cmd.op = OP_SPECIAL;
                    n_state  = ST_PAIR;
                end else begin
                    o_cmd.op = OP_DIV_RATIO;
                    n_state  = ST_DIV1;
                end
            end
            ST_DIV1: begin
                o_cmd.op = OP_DIV_STEP;
                n_cnt    = r_cnt + 5'd1;
                if (iter_end) begin
                    n_state = ST_SRA;
                end
            end
            ST_SRA: begin
                o_cmd.op = OP_SAVE_RA;
                n_state  = ST_MRR;
            end
            ST_MRR: begin
                o_cmd.mul_sel = MS_RR;
                n_state       = ST_SQI;
            end
            ST_SQI: begin
                o_cmd.op = OP_SQ_INIT;
                n_cnt    = '0;
                n_state  = ST_SQ;
            end
            ST_SQ: begin
                o_cmd.op = OP_SQ_STEP;
                n_cnt    = r_cnt + 5'd1;
                if (iter_end) begin
                    n_state = ST_D2I;
                end
            end
            ST_D2I: begin
                o_cmd.op = OP_DIV_U;
                n_cnt    = '0;
                n_state  = ST_DIV2;
            end
            ST_DIV2: begin
                o_cmd.op = OP_DIV_STEP;
                n_cnt    = r_cnt + 5'd1;
                if (iter_end) begin
                    n_state = ST_SU;
                end
            end
            ST_SU: begin
                o_cmd.op = OP_SAVE_U;
                n_state  = ST_MUR;
            end
            ST_MUR: begin
                o_cmd.mul_sel = MS_UR;
                n_state       = ST_CS;
            end
            ST_CS: begin
                o_cmd.op = OP_SET_CS;
                n_state  = ST_PAIR;
            end
            ST_PAIR: begin
                o_cmd.rd_q   = r_onq;
                o_cmd.wr_src = WS_RES;
                n_step       = r_step + 4'd1;
                unique case (r_step)
                    PS_RDX: begin
                        o_raddr_r = xr;
                        o_raddr_q = xq;
                    end
                    PS_RDY: begin
                        o_raddr_r = yr;
                        o_raddr_q = yq;
                        o_cmd.op  = OP_LDX;
                    end
                    PS_LDY: o_cmd.op = OP_LDY;
                    PS_MCX: o_cmd.mul_sel = MS_CX;
                    PS_MSY: begin
                        o_cmd.mul_sel = MS_SY;
                        o_cmd.acc_op  = AC_LOAD;
                    end
                    PS_MSX: begin
                        o_cmd.mul_sel = MS_SX;
                        o_cmd.acc_op  = AC_SUB;
                    end
                    PS_MCY: begin
                        o_cmd.mul_sel = MS_CY;
                        o_cmd.acc_op  = AC_LOAD;
                        o_cmd.res_en  = 1'b1;
                    end
                    PS_WRX: begin
                        o_cmd.acc_op = AC_ADD;
                        o_cmd.wr_r   = ~r_onq;
                        o_cmd.wr_q   = r_onq;
                        o_waddr      = r_onq ? xq : QAW'(xr);
                    end
                    PS_RSY: o_cmd.res_en = 1'b1;
                    PS_WRY: begin
                        o_cmd.wr_r = ~r_onq;
                        o_cmd.wr_q = r_onq;
                        o_waddr    = r_onq ? yq : QAW'(yr);
                        n_step     = PS_RDX;
                        if (!r_onq) begin
                            if (r_k == RW'(COLS - 1)) begin
                                n_k   = '0;
                                n_onq = 1'b1;
                            end else begin
                                n_k = r_k + RW'(1);
                            end
                        end else if (r_k != RW'(ROWS - 1)) begin
                            n_k = r_k + RW'(1);
                        end else if (int'(r_i) > int'(r_j) + 1) begin
                            n_i     = im1;
                            n_state = ST_RA;
                        end else if (int'(r_j) + 1 < COLS && int'(r_j) + 2 < ROWS) begin
                            n_j     = r_j + RW'(1);
                            n_i     = RW'(ROWS - 1);
                            n_state = ST_RA;
                        end else begin
                            n_row   = '0;
                            n_col   = '0;
                            n_mat   = 1'b0;
                            n_state = ST_EMIT;
                        end
                    end
                    default: n_step = PS_RDX;
                endcase
            end
            ST_EMIT: begin
                o_cmd.rd_q = ~r_mat;
                o_raddr_r  = raddr(r_row, r_col);
                o_raddr_q  = qaddr(r_row, r_col);
                n_valid    = 1'b1;
                n_emat     = r_mat;
                n_erow     = 2'(r_row);
                n_ecol     = 2'(r_col);
                if (col_end) begin
                    n_col = '0;
                    if (r_row == RW'(ROWS - 1)) begin
                        n_row = '0;
                        if (r_mat) begin
                            n_elast = 1'b1;
                            n_state = ST_LOAD;
                        end else begin
                            n_mat = 1'b1;
                        end
                    end else begin
                        n_row = r_row + RW'(1);
                    end
                end else begin
                    n_col = r_col + RW'(1);
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_lc    <= '0;
            r_valid <= 1'b0;
            r_elast <= 1'b0;
        end else begin
            r_state <= n_state;
            r_lc    <= n_lc;
            r_valid <= n_valid;
            r_elast <= n_elast;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt  <= n_cnt;
        r_step <= n_step;
        r_i    <= n_i;
        r_j    <= n_j;
        r_k    <= n_k;
        r_row  <= n_row;
        r_col  <= n_col;
        r_onq  <= n_onq;
        r_mat  <= n_mat;
        r_emat <= n_emat;
        r_erow <= n_erow;
        r_ecol <= n_ecol;
    end

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(o_busy) && $past(i_rst_n)) |-> (o_valid && o_last_of_run))
        else $error("busy dropped without final R word");

    a_valid_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == ST_EMIT))
        else $error("result strobe outside emission");

    a_full_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && r_lc == RAW'(R_SIZE - 1)) |=> o_busy)
        else $error("final load did not start decomposition");

    a_last_is_r: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last_of_run |-> (o_valid && o_which_matrix))
        else $error("last flag on a non-R word");
endmodule
`default_nettype wire

FILE: tb/sv/qr_decomposition_givens_chk.sv
// Checker for the Givens QR block: predicts Q and R per loaded matrix and compares each word.
`timescale 1ns / 1ps
module qr_decomposition_givens_chk #(
    parameter int ROWS = 4,
    parameter int COLS = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic        i_busy,
    input  wire logic [31:0] i_element,
    input  wire logic        i_valid,
    input  wire logic        i_which_matrix,
    input  wire logic [1:0]  i_row,
    input  wire logic [1:0]  i_col,
    input  wire logic [31:0] i_value,
    input  wire logic        i_last_of_run,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_words_in,
    output int               o_words_out
);
    localparam longint ONE = 65536;

    typedef struct {
        logic        which;
        logic [1:0]  row;
        logic [1:0]  col;
        logic [31:0] value;
        logic        last;
    } t_out_word;

    t_out_word          expected_words[$];
    logic signed [31:0] r_mat[ROWS*COLS];
    logic signed [31:0] q_mat[ROWS*ROWS];
    int                 loaded;

    function automatic logic signed [31:0] sat32(longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    task automatic givens_coeffs(input longint a, input longint b,
                                 output longint c, output longint s);
        longint          sa, sb, ma, mb, r, u;
        longint unsigned t, q;
        sa = (a > 0) ? 1 : ((a < 0) ? -1 : 0);
        sb = (b > 0) ? 1 : ((b < 0) ? -1 : 0);
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        if (b == 0) begin
            c = (sa == 0) ? ONE : sa * ONE;
            s = 0;
        end else if (a == 0) begin
            c = 0;
            s = -sb * ONE;
        end else begin
            if (mb > ma) r = (a * ONE) / b;
            else         r = (b * ONE) / a;
            t = 64'd65536 + ((r * r) >> 16);
            q = int_sqrt(t << 16);
            u = longint'((64'd65536 << 16) / q);
            if (mb > ma) begin
                s = -sb * u;
                c = -((s * r) / ONE);
            end else begin
                c = sa * u;
                s = -((c * r) / ONE);
            end
        end
    endtask

    task automatic rotate_words(inout logic signed [31:0] x, inout logic signed [31:0] y,
                                input longint c, input longint s);
        longint xv, yv;
        xv = x;
        yv = y;
        x  = sat32((c * xv - s * yv) / ONE);
        y  = sat32((s * xv + c * yv) / ONE);
    endtask

    task automatic factor_matrix();
        longint    c, s;
        t_out_word w;
        for (int i = 0; i < ROWS; i++)
            for (int k = 0; k < ROWS; k++)
                q_mat[i*ROWS+k] = (i == k) ? 32'sd65536 : 32'sd0;
        for (int j = 0; j < COLS; j++)
            for (int i = ROWS - 1; i > j; i--) begin
                givens_coeffs(r_mat[(i-1)*COLS+j], r_mat[i*COLS+j], c, s);
                for (int k = 0; k < COLS; k++)
                    rotate_words(r_mat[(i-1)*COLS+k], r_mat[i*COLS+k], c, s);
                for (int k = 0; k < ROWS; k++)
                    rotate_words(q_mat[k*ROWS+i-1], q_mat[k*ROWS+i], c, s);
            end
        for (int i = 0; i < ROWS; i++)
            for (int k = 0; k < ROWS; k++) begin
                w = '{1'b0, i[1:0], k[1:0], q_mat[i*ROWS+k], 1'b0};
                expected_words.push_back(w);
            end
        for (int i = 0; i < ROWS; i++)
            for (int k = 0; k < COLS; k++) begin
                w = '{1'b1, i[1:0], k[1:0], r_mat[i*COLS+k],
                      (i == ROWS - 1 && k == COLS - 1)};
                expected_words.push_back(w);
            end
    endtask

    always @(posedge i_clk) begin
        t_out_word w;
        if (!i_rst_n) begin
            loaded = 0;
            expected_words.delete();
            o_fail_count <= 0;
            o_pending    <= 0;
            o_words_in   <= 0;
            o_words_out  <= 0;
        end else begin
            if (i_valid) begin
                o_words_out <= o_words_out + 1;
                if (expected_words.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("ERROR: unexpected word mat=%0d row=%0d col=%0d val=%h",
                                 i_which_matrix, i_row, i_col, i_value);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    w = expected_words.pop_front();
                    if (w.which !== i_which_matrix || w.row !== i_row || w.col !== i_col ||
                        w.value !== i_value || w.last !== i_last_of_run) begin
                        if (o_fail_count < 10)
                            $display({"ERROR: exp mat=%0d row=%0d col=%0d val=%h last=%0d,",
                                      " got mat=%0d row=%0d col=%0d val=%h last=%0d"},
                                     w.which, w.row, w.col, w.value, w.last,
                                     i_which_matrix, i_row, i_col, i_value, i_last_of_run);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_start && !i_busy) begin
                o_words_in <= o_words_in + 1;
                r_mat[loaded] = i_element;
                loaded++;
                if (loaded == ROWS * COLS) begin
                    factor_matrix();
                    loaded = 0;
                end
            end
            o_pending <= expected_words.size();
        end
    end
endmodule

FILE: tb/sv/qr_decomposition_givens_tb.sv
// Testbench top for the Givens QR block: drives matrices and reports the verdict.
`timescale 1ns / 1ps
module qr_decomposition_givens_tb;
    localparam int ROWS  = 4;
    localparam int COLS  = 4;
    localparam int LIMIT = 20000;

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic signed [31:0]  i_element;
    logic                busy;
    logic                o_valid;
    logic                o_which_matrix;
    logic [1:0]          o_row;
    logic [1:0]          o_col;
    logic signed [31:0]  o_value;
    logic                o_last_of_run;
    int                  fail_count;
    int                  pending;
    int                  words_in;
    int                  words_out;
    int                  idle_cycles;
    int                  matrices_done;

    qr_decomposition_givens #(.ROWS(ROWS), .COLS(COLS)) u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .i_element(i_element),
        .busy(busy), .o_valid(o_valid), .o_which_matrix(o_which_matrix),
        .o_row(o_row), .o_col(o_col), .o_value(o_value), .o_last_of_run(o_last_of_run)
    );

    qr_decomposition_givens_chk #(.ROWS(ROWS), .COLS(COLS)) u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_busy(busy),
        .i_element(i_element), .i_valid(o_valid), .i_which_matrix(o_which_matrix),
        .i_row(o_row), .i_col(o_col), .i_value(o_value), .i_last_of_run(o_last_of_run),
        .o_fail_count(fail_count), .o_pending(pending),
        .o_words_in(words_in), .o_words_out(words_out)
    );

    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // watchdog on cycles with no word moving either way
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= LIMIT) begin
                $display("Timeout: no progress for %0d cycles", LIMIT);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    task automatic send_word(input logic [31:0] w);
        start     <= 1'b1;
        i_element <= w;
        forever begin
            @(negedge i_clk);
            if (!busy) break;
            @(posedge i_clk);
        end
        @(posedge i_clk);
    endtask

    task automatic idle_gap();
        int n;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: n = 0;
            5, 6, 7:       n = $urandom_range(1, 3);
            8:             n = $urandom_range(4, 10);
            default:       n = $urandom_range(20, 60);
        endcase
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    function automatic logic [31:0] pick_word(int zero_pct);
        if ($urandom_range(0, 99) < zero_pct) return 32'h0;
        case ($urandom_range(0, 9))
            0, 1, 2:    return $urandom();
            3, 4, 5, 6: return {{14{1'b0}}, 18'($urandom())} - 32'h0002_0000;
            7:          return $urandom_range(0, 3) == 0 ? 32'h8000_0000 :
                               $urandom_range(0, 2) == 0 ? 32'h7fff_ffff :
                               $urandom_range(0, 1) ? 32'hffff_ffff : 32'h0000_0001;
            default:    return {{8{1'b0}}, 24'($urandom())} - 32'h0080_0000;
        endcase
    endfunction

    logic [31:0] directed_words[32];

    initial begin
        int zero_pct;
        i_rst_n   <= 1'b0;
        start     <= 1'b0;
        i_element <= '0;
        matrices_done = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // all-zero matrix: b==0 with a==0 everywhere
        for (int k = 0; k < 16; k++) directed_words[k] = 32'h0;
        // extremes; column 0 gives b==0 with a>0, then a==0 with b!=0
        directed_words[16] = 32'h0000_0000; directed_words[17] = 32'h7fff_ffff;
        directed_words[18] = 32'h8000_0000; directed_words[19] = 32'hffff_ffff;
        directed_words[20] = 32'h0000_0000; directed_words[21] = 32'h8000_0000;
        directed_words[22] = 32'h7fff_ffff; directed_words[23] = 32'h0000_0001;
        directed_words[24] = 32'h0007_0000; directed_words[25] = 32'hfffd_0000;
        directed_words[26] = 32'h0000_8000; directed_words[27] = 32'h0002_0000;
        directed_words[28] = 32'h0000_0000; directed_words[29] = 32'hfff0_0000;
        directed_words[30] = 32'h0003_0000; directed_words[31] = 32'hfffb_0000;
        for (int k = 0; k < 32; k++) send_word(directed_words[k]);
        start <= 1'b0;
        matrices_done += 2;

        for (int m = 0; m < 22; m++) begin
            zero_pct = ($urandom_range(0, 3) == 0) ? 40 : 5;
            for (int k = 0; k < ROWS * COLS; k++) begin
                send_word(pick_word(zero_pct));
                idle_gap();
            end
            matrices_done++;
        end
        start <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);

        $display("Loaded %0d words into %0d matrices, checked %0d output words.",
                 words_in, matrices_done, words_out);
        $display("Covered zero, extreme and random operands with random start gaps.");
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Mismatches: %0d", fail_count);
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

FILE: files.f
hw/rtl/qrg_pkg.sv
hw/rtl/qrg_ram.sv
hw/rtl/qrg_datapath.sv
hw/rtl/qrg_ctrl.sv
hw/rtl/qr_decomposition_givens.sv
tb/sv/qr_decomposition_givens_chk.sv
tb/sv/qr_decomposition_givens_tb.sv
